// File: src/vupst_pkg.sv
package vupst_pkg;

   localparam int OpcodeWidth = 2;
   localparam int KindWidth   = 4;
   localparam int OpWidth     = 5;
   localparam int StageWidth  = 4;
   localparam int IndexWidth  = 6;

   typedef logic [KindWidth-1:0]  kind_type;
   typedef logic [OpWidth-1:0]    op_type;
   typedef logic [IndexWidth-1:0] index_type;

   typedef enum logic [OpcodeWidth-1:0] {
      OPC_ISSUE   = 2'd0,
      OPC_ADVANCE = 2'd1,
      OPC_QUERY   = 2'd2,
      OPC_SPARE   = 2'd3
   } opcode_type;

   typedef enum logic [StageWidth-1:0] {
      ST_M  = 4'd0,
      ST_T  = 4'd1,
      ST_X  = 4'd2,
      ST_Y  = 4'd3,
      ST_Z  = 4'd4,
      ST_S  = 4'd5,
      ST_IY = 4'd6,
      ST_IZ = 4'd7,
      ST_D  = 4'd8,
      ST_F  = 4'd9,
      ST_N  = 4'd10,
      ST_P  = 4'd11
   } stage_type;

   // unit kinds
   localparam kind_type K_FMAC   = 4'd0;
   localparam kind_type K_LSU    = 4'd1;
   localparam kind_type K_XGKICK = 4'd2;
   localparam kind_type K_FLAG   = 4'd3;
   localparam kind_type K_RANDOM = 4'd4;
   localparam kind_type K_IALU   = 4'd5;
   localparam kind_type K_BRANCH = 4'd6;
   localparam kind_type K_IREG   = 4'd7;
   localparam kind_type K_WAITQ  = 4'd8;
   localparam kind_type K_WAITP  = 4'd9;
   localparam kind_type K_VIFCTL = 4'd10;
   localparam kind_type K_FDIV   = 4'd11;
   localparam kind_type K_EFU    = 4'd12;

   // operation classes
   localparam op_type OP_FCSET  = 5'd1;
   localparam op_type OP_FSSET  = 5'd2;
   localparam op_type OP_RGET   = 5'd3;
   localparam op_type OP_RNEXT  = 5'd4;
   localparam op_type OP_DIV    = 5'd5;
   localparam op_type OP_SQRT   = 5'd6;
   localparam op_type OP_RSQRT  = 5'd7;
   localparam op_type OP_EATAN  = 5'd8;
   localparam op_type OP_EATNXY = 5'd9;
   localparam op_type OP_EATNXZ = 5'd10;
   localparam op_type OP_EEXP   = 5'd11;
   localparam op_type OP_ELENG  = 5'd12;
   localparam op_type OP_ERSADD = 5'd13;
   localparam op_type OP_ERSQRT = 5'd14;
   localparam op_type OP_ERCPR  = 5'd15;
   localparam op_type OP_ESQRT  = 5'd16;
   localparam op_type OP_ESUM   = 5'd17;
   localparam op_type OP_ERLENG = 5'd18;
   localparam op_type OP_ESADD  = 5'd19;
   localparam op_type OP_ESIN   = 5'd20;

   typedef enum logic [2:0] {
      PATH_TWO  = 3'd0,
      PATH_SIX  = 3'd1,
      PATH_IALU = 3'd2,
      PATH_FDIV = 3'd3,
      PATH_EFU  = 3'd4,
      PATH_NONE = 3'd5
   } path_type;

   typedef struct packed {
      index_type latency;
      logic      bad;
   } timing_type;

   function automatic path_type path_of(kind_type kind, op_type op);
      path_type p;
      case (kind)
         K_FMAC, K_LSU, K_XGKICK: p = PATH_SIX;
         K_FLAG:   p = (op == OP_FCSET || op == OP_FSSET) ? PATH_SIX : PATH_TWO;
         K_RANDOM: p = (op == OP_RGET || op == OP_RNEXT) ? PATH_SIX : PATH_TWO;
         K_IALU:   p = PATH_IALU;
         K_BRANCH, K_IREG, K_WAITQ, K_WAITP, K_VIFCTL: p = PATH_TWO;
         K_FDIV:   p = PATH_FDIV;
         K_EFU:    p = PATH_EFU;
         default:  p = PATH_NONE;
      endcase
      return p;
   endfunction

   function automatic timing_type issue_timing(kind_type kind, op_type op);
      timing_type t;
      t.latency = '0;
      t.bad     = 1'b0;
      if (kind == K_FDIV) begin
         case (op)
            OP_DIV, OP_SQRT: t.latency = 6'd6;
            OP_RSQRT:        t.latency = 6'd12;
            default:         t.bad = 1'b1;
         endcase
      end else if (kind == K_EFU) begin
         case (op)
            OP_EATAN, OP_EATNXY, OP_EATNXZ: t.latency = 6'd53;
            OP_EEXP:                        t.latency = 6'd43;
            OP_ELENG, OP_ERSADD, OP_ERSQRT: t.latency = 6'd17;
            OP_ERCPR, OP_ESQRT, OP_ESUM:    t.latency = 6'd11;
            OP_ERLENG:                      t.latency = 6'd23;
            OP_ESADD:                       t.latency = 6'd10;
            OP_ESIN:                        t.latency = 6'd28;
            default:                        t.bad = 1'b1;
         endcase
      end
      return t;
   endfunction

endpackage

// File: src/vupst_if.sv
interface vupst_req_if
   import vupst_pkg::*;
();
   logic     valid;
   logic     ready;
   logic [OpcodeWidth-1:0] opcode;
   kind_type unit_type;
   op_type   operation;
   kind_type requested_type;

   modport source (output valid, output opcode, output unit_type, output operation,
                   output requested_type, input ready);
   modport sink   (input valid, input opcode, input unit_type, input operation,
                   input requested_type, output ready);
endinterface

interface vupst_rsp_if
   import vupst_pkg::*;
();
   logic      valid;
   logic      ready;
   logic [StageWidth-1:0] stage;
   index_type stage_count;
   logic      done_res;
   logic      done_next;
   logic      dest_ready;
   logic      hazard;
   logic      error;

   modport source (output valid, output stage, output stage_count, output done_res,
                   output done_next, output dest_ready, output hazard, output error,
                   input ready);
   modport sink   (input valid, input stage, input stage_count, input done_res,
                   input done_next, input dest_ready, input hazard, input error,
                   output ready);
endinterface

// File: src/vector_unit_pipeline_stage_tracker_core.sv
// Follows one in-flight vector-unit instruction through its pipeline stages.
// Every request transfer (issue, advance or query) yields exactly one response
// transfer that describes the tracker state after that request. The state update
// and the response are computed in the same cycle the request is taken, so the
// response appears in the cycle after the request transfer; a new request is taken
// every clock as long as the response register is empty or being drained, which
// gives a sustained rate of one item per cycle. A stalled response holds the
// request side off only for as long as the single response register stays full.
module vector_unit_pipeline_stage_tracker_core
   import vupst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   vupst_req_if.sink   req_if,
   vupst_rsp_if.source rsp_if
);

   // tracker state
   stage_type cur_stage_ff, cur_stage_in;
   index_type cur_index_ff, cur_index_in;
   index_type latency_ff,   latency_in;
   kind_type  kind_ff,      kind_in;
   op_type    op_class_ff,  op_class_in;
   logic      finished_ff,  finished_in;
   logic      bad_timing_ff, bad_timing_in;

   // response register
   logic      rsp_valid_ff, rsp_valid_in;
   stage_type rsp_stage_ff;
   index_type rsp_count_ff;
   logic      rsp_done_ff, rsp_done_next_ff, rsp_dest_ff, rsp_hazard_ff, rsp_error_ff;

   logic       take;
   opcode_type opcode;
   timing_type timing;
   path_type   path;
   stage_type  mid_stage, last_stage;
   logic       done_next_in, dest_ready_in, hazard_in;
   logic       at_last_count;

   // accept while the response slot is free or emptying this cycle
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign take         = req_if.valid && req_if.ready;
   assign opcode       = opcode_type'(req_if.opcode);
   assign timing       = issue_timing(req_if.unit_type, req_if.operation);
   assign path         = path_of(kind_ff, op_class_ff);

   // next tracker state
   always_comb begin
      cur_stage_in  = cur_stage_ff;
      cur_index_in  = cur_index_ff;
      latency_in    = latency_ff;
      kind_in       = kind_ff;
      op_class_in   = op_class_ff;
      finished_in   = finished_ff;
      bad_timing_in = bad_timing_ff;
      mid_stage     = (path == PATH_FDIV) ? ST_D : ST_N;
      last_stage    = (path == PATH_FDIV) ? ST_F : ST_P;

      if (take) begin
         case (opcode)
            OPC_ISSUE: begin
               kind_in       = req_if.unit_type;
               op_class_in   = req_if.operation;
               cur_stage_in  = ST_M;
               cur_index_in  = '0;
               finished_in   = 1'b0;
               latency_in    = timing.latency;
               bad_timing_in = timing.bad;
            end
            OPC_ADVANCE: begin
               case (path)
                  PATH_TWO: begin
                     cur_stage_in = ST_T;
                     finished_in  = 1'b1;
                  end
                  PATH_SIX: begin
                     case (cur_stage_ff)
                        ST_M: cur_stage_in = ST_T;
                        ST_T: cur_stage_in = ST_X;
                        ST_X: cur_stage_in = ST_Y;
                        ST_Y: cur_stage_in = ST_Z;
                        ST_Z: begin
                           cur_stage_in = ST_S;
                           finished_in  = 1'b1;
                        end
                        default: cur_stage_in = cur_stage_ff;
                     endcase
                  end
                  PATH_IALU: begin
                     case (cur_stage_ff)
                        ST_M:  cur_stage_in = ST_T;
                        ST_T:  cur_stage_in = ST_X;
                        ST_X:  cur_stage_in = ST_IY;
                        ST_IY: cur_stage_in = ST_IZ;
                        ST_IZ: begin
                           cur_stage_in = ST_S;
                           finished_in  = 1'b1;
                        end
                        default: cur_stage_in = cur_stage_ff;
                     endcase
                  end
                  PATH_FDIV, PATH_EFU: begin
                     // counted divider / function unit
                     if (cur_stage_ff == ST_M) begin
                        cur_stage_in = ST_T;
                     end else if (cur_stage_ff == ST_T) begin
                        cur_stage_in = mid_stage;
                        cur_index_in = index_type'(1);
                     end else if (cur_stage_ff == mid_stage && cur_index_ff < latency_ff) begin
                        cur_index_in = cur_index_ff + index_type'(1);
                     end else begin
                        cur_stage_in = last_stage;
                        cur_index_in = '0;
                        finished_in  = 1'b1;
                     end
                  end
                  default: cur_stage_in = cur_stage_ff;
               endcase
            end
            default: cur_stage_in = cur_stage_ff; // query and spare opcode
         endcase
      end
   end

   // response fields from the updated state
   always_comb begin
      at_last_count = cur_index_in == latency_in;
      case (path_of(kind_in, op_class_in))
         PATH_TWO:  done_next_in = cur_stage_in == ST_M;
         PATH_SIX:  done_next_in = cur_stage_in == ST_Z;
         PATH_IALU: done_next_in = cur_stage_in == ST_IZ;
         PATH_FDIV: done_next_in = cur_stage_in == ST_D && at_last_count;
         PATH_EFU:  done_next_in = cur_stage_in == ST_N && at_last_count;
         default:   done_next_in = 1'b0;
      endcase

      dest_ready_in = (kind_in == K_FMAC || kind_in == K_LSU || kind_in == K_RANDOM)
                      && cur_stage_in == ST_Z;

      // structural hazard against the requested kind
      if (req_if.requested_type == K_FDIV || req_if.requested_type == K_WAITQ) begin
         hazard_in = kind_in == K_FDIV;
      end else if (req_if.requested_type == K_EFU || req_if.requested_type == K_WAITP) begin
         hazard_in = kind_in == K_EFU && !(cur_stage_in == ST_N && at_last_count);
      end else begin
         hazard_in = 1'b0;
      end

      rsp_valid_in = take || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_stage_ff  <= ST_M;
         cur_index_ff  <= '0;
         latency_ff    <= '0;
         kind_ff       <= '0;
         op_class_ff   <= '0;
         finished_ff   <= 1'b0;
         bad_timing_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cur_stage_ff  <= cur_stage_in;
         cur_index_ff  <= cur_index_in;
         latency_ff    <= latency_in;
         kind_ff       <= kind_in;
         op_class_ff   <= op_class_in;
         finished_ff   <= finished_in;
         bad_timing_ff <= bad_timing_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // response payload, loaded on every request transfer
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_stage_ff     <= cur_stage_in;
         rsp_count_ff     <= cur_index_in;
         rsp_done_ff      <= finished_in;
         rsp_done_next_ff <= done_next_in;
         rsp_dest_ff      <= dest_ready_in;
         rsp_hazard_ff    <= hazard_in;
         rsp_error_ff     <= bad_timing_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.stage       = rsp_stage_ff;
   assign rsp_if.stage_count = rsp_count_ff;
   assign rsp_if.done_res    = rsp_done_ff;
   assign rsp_if.done_next   = rsp_done_next_ff;
   assign rsp_if.dest_ready  = rsp_dest_ff;
   assign rsp_if.hazard      = rsp_hazard_ff;
   assign rsp_if.error       = rsp_error_ff;

endmodule
